@@ rtl/core/wsfr_pkg.sv @@
//------------------------------------------------------------------------------
// wsfr_pkg
// Shared types and constants for the WebSocket frame receiver.
//------------------------------------------------------------------------------
`default_nettype none

package wsfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_MASK = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_RSV  = 2'd1,
        ERR_MASK = 2'd2,
        ERR_SIZE = 2'd3
    } err_t;

    localparam logic [3:0]  OPC_CLOSE         = 4'h8;
    localparam logic [6:0]  LEN_EXT16         = 7'd126;
    localparam logic [6:0]  LEN_EXT64         = 7'd127;
    localparam logic [7:0]  RSV_BITS          = 8'h70;
    localparam logic [3:0]  HCNT_EXT16        = 4'd2;
    localparam logic [3:0]  HCNT_EXT64        = 4'd8;
    localparam logic [3:0]  HCNT_MASK         = 4'd4;
    localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd10485760;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       frame_end;
        logic       message_end;
        err_t       error_code;
    } wsfr_result_t;

endpackage

`default_nettype wire

@@ rtl/core/websocket_frame_receiver.sv @@
// Each result is registered in a two-entry result buffer before it is output.
// Throughput: one received byte per cycle unless both buffer entries are full;
// the parser updates its state on every transfer until an error, and the buffer
// keeps input open while one result waits. Reset (rst_n, asynchronous, active
// low) returns the parser to the first header byte, clears the closed and dead
// flags, empties the buffer and sets the payload limit to 10485760 bytes.
//------------------------------------------------------------------------------
// websocket_frame_receiver
// Client-to-server WebSocket frame deframer with payload unmasking.
//------------------------------------------------------------------------------
`default_nettype none

module websocket_frame_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       kind,
    output logic [7:0]       data,
    output logic [3:0]       opcode,
    output logic             frame_end,
    output logic             message_end,
    output logic [1:0]       error_code
);
    import wsfr_pkg::*;

    logic [31:0]  max_payload_reg;
    logic         accept;
    logic         res_valid;
    wsfr_result_t res;
    wsfr_result_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    assign accept = in_valid && in_ready;

    wsfr_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (rx_byte),
        .max_payload (max_payload_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    wsfr_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (res_valid),
        .push_data  (res),
        .can_accept (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .head       (head)
    );

    assign kind        = head.kind;
    assign data        = head.data;
    assign opcode      = head.opcode;
    assign frame_end   = head.frame_end;
    assign message_end = head.message_end;
    assign error_code  = head.error_code;

endmodule

`default_nettype wire

@@ rtl/core/wsfr_parse.sv @@
//------------------------------------------------------------------------------
// wsfr_parse
// Frame header parser, length check and payload unmasking, one byte per cycle while accept is high.
//------------------------------------------------------------------------------
`default_nettype none

module wsfr_parse (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire logic [7:0]            rx_byte,
    input  wire logic [31:0]           max_payload,
    output logic                       res_valid,
    output wsfr_pkg::wsfr_result_t     res
);
    import wsfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hcnt_reg, hcnt_next;
    logic        fin_reg, fin_next;
    logic [3:0]  msgop_reg, msgop_next;
    logic        in_frag_reg, in_frag_next;
    logic [31:0] len_reg, len_next;
    logic        len_ovf_reg, len_ovf_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  midx_reg, midx_next;
    logic        closed_reg, closed_next;
    logic        dead_reg, dead_next;

    logic [31:0] len_shifted;
    logic        len_shift_ovf;
    logic [7:0]  key_byte;
    logic        last_byte;

    assign len_shifted   = {len_reg[23:0], rx_byte};
    assign len_shift_ovf = len_ovf_reg | (len_reg[31:24] != 8'd0);
    assign last_byte     = (rem_reg == 32'd1);

    always_comb
    begin
        case (midx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            hcnt_reg    <= 4'd0;
            fin_reg     <= 1'b0;
            msgop_reg   <= 4'd0;
            in_frag_reg <= 1'b0;
            len_reg     <= 32'd0;
            len_ovf_reg <= 1'b0;
            rem_reg     <= 32'd0;
            key_reg     <= 32'd0;
            midx_reg    <= 2'd0;
            closed_reg  <= 1'b0;
            dead_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            hcnt_reg    <= hcnt_next;
            fin_reg     <= fin_next;
            msgop_reg   <= msgop_next;
            in_frag_reg <= in_frag_next;
            len_reg     <= len_next;
            len_ovf_reg <= len_ovf_next;
            rem_reg     <= rem_next;
            key_reg     <= key_next;
            midx_reg    <= midx_next;
            closed_reg  <= closed_next;
            dead_reg    <= dead_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        hcnt_next    = hcnt_reg;
        fin_next     = fin_reg;
        msgop_next   = msgop_reg;
        in_frag_next = in_frag_reg;
        len_next     = len_reg;
        len_ovf_next = len_ovf_reg;
        rem_next     = rem_reg;
        key_next     = key_reg;
        midx_next    = midx_reg;
        closed_next  = closed_reg;
        dead_next    = dead_reg;
        res_valid    = 1'b0;
        res          = '0;

        if (accept && !dead_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    fin_next = rx_byte[7];
                    if (!in_frag_reg)
                    begin
                        msgop_next = rx_byte[3:0];
                    end
                    // The count doubles as a reserved-bits flag until the second byte.
                    hcnt_next  = ((rx_byte & RSV_BITS) != 8'd0) ? 4'd1 : 4'd0;
                    phase_next = PH_HDR1;
                end
                PH_HDR1:
                begin
                    len_next     = 32'd0;
                    len_ovf_next = 1'b0;
                    if (hcnt_reg != 4'd0)
                    begin
                        dead_next      = 1'b1;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_RSV;
                    end
                    else if (!rx_byte[7])
                    begin
                        dead_next      = 1'b1;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_MASK;
                    end
                    else if (rx_byte[6:0] == LEN_EXT16)
                    begin
                        hcnt_next  = HCNT_EXT16;
                        phase_next = PH_EXT;
                    end
                    else if (rx_byte[6:0] == LEN_EXT64)
                    begin
                        hcnt_next  = HCNT_EXT64;
                        phase_next = PH_EXT;
                    end
                    else if ({25'd0, rx_byte[6:0]} > max_payload)
                    begin
                        dead_next      = 1'b1;
                        res_valid      = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_SIZE;
                    end
                    else
                    begin
                        rem_next   = {25'd0, rx_byte[6:0]};
                        hcnt_next  = HCNT_MASK;
                        phase_next = PH_MASK;
                    end
                end
                PH_EXT:
                begin
                    // Only the low 32 bits are kept; anything shifted past them
                    // makes the length too large for any limit.
                    len_next     = len_shifted;
                    len_ovf_next = len_shift_ovf;
                    hcnt_next    = hcnt_reg - 4'd1;
                    if (hcnt_reg == 4'd1)
                    begin
                        if (len_shift_ovf || (len_shifted > max_payload))
                        begin
                            dead_next      = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_SIZE;
                        end
                        else
                        begin
                            rem_next   = len_shifted;
                            hcnt_next  = HCNT_MASK;
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_MASK:
                begin
                    key_next  = {key_reg[23:0], rx_byte};
                    hcnt_next = hcnt_reg - 4'd1;
                    if (hcnt_reg == 4'd1)
                    begin
                        midx_next = 2'd0;
                        if (rem_reg == 32'd0)
                        begin
                            res_valid       = !closed_reg;
                            res.kind        = KIND_EMPTY;
                            res.opcode      = msgop_reg;
                            res.frame_end   = 1'b1;
                            res.message_end = fin_reg;
                            in_frag_next    = !fin_reg;
                            if (fin_reg && (msgop_reg == OPC_CLOSE))
                            begin
                                closed_next = 1'b1;
                            end
                            phase_next = PH_HDR0;
                            hcnt_next  = 4'd0;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
                PH_DATA:
                begin
                    midx_next       = midx_reg + 2'd1;
                    rem_next        = rem_reg - 32'd1;
                    res_valid       = !closed_reg;
                    res.kind        = KIND_DATA;
                    res.data        = rx_byte ^ key_byte;
                    res.opcode      = msgop_reg;
                    res.frame_end   = last_byte;
                    res.message_end = last_byte & fin_reg;
                    if (last_byte)
                    begin
                        in_frag_next = !fin_reg;
                        if (fin_reg && (msgop_reg == OPC_CLOSE))
                        begin
                            closed_next = 1'b1;
                        end
                        phase_next = PH_HDR0;
                        hcnt_next  = 4'd0;
                        midx_next  = 2'd0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/wsfr_obuf.sv @@
//------------------------------------------------------------------------------
// wsfr_obuf
// Two-entry result buffer: an output register plus a skid register.
//------------------------------------------------------------------------------
`default_nettype none

module wsfr_obuf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire wsfr_pkg::wsfr_result_t push_data,
    output logic                       can_accept,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output wsfr_pkg::wsfr_result_t     head
);
    import wsfr_pkg::*;

    logic         head_valid_reg, head_valid_next;
    logic         skid_valid_reg, skid_valid_next;
    wsfr_result_t head_reg, head_next;
    wsfr_result_t skid_reg, skid_next;
    logic         pop;

    assign pop        = head_valid_reg && out_ready;
    assign can_accept = !skid_valid_reg;
    assign out_valid  = head_valid_reg;
    assign head       = head_reg;

    always_comb
    begin
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next       = head_reg;
        skid_next       = skid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                head_next       = push_data;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = push_data;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

@@ rtl/core/wsfr_check.sv @@
//------------------------------------------------------------------------------
// wsfr_check
// Port-level checks for the WebSocket frame receiver, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module wsfr_check (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [1:0] kind,
    input wire logic [7:0] data,
    input wire logic       frame_end,
    input wire logic       message_end,
    input wire logic [1:0] error_code
);
    import wsfr_pkg::*;

    // An error result carries only its code.
    a_error_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_ERROR) |->
            (data == 8'd0) && !frame_end && !message_end && (error_code != ERR_NONE))
        else $error("error result with stray fields");

    // An empty frame marker always closes its frame and holds no data.
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_EMPTY) |->
            frame_end && (data == 8'd0) && (error_code == ERR_NONE))
        else $error("empty frame marker malformed");

    // Nothing follows an error, so the buffer is empty after its transfer.
    a_dead_after_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && (kind == KIND_ERROR) |=> !out_valid)
        else $error("result after protocol error");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data) && $stable(kind))
        else $error("output changed while stalled");

endmodule

bind websocket_frame_receiver wsfr_check u_wsfr_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .data        (data),
    .frame_end   (frame_end),
    .message_end (message_end),
    .error_code  (error_code)
);

`default_nettype wire

@@ bench/websocket_frame_receiver_test.sv @@
//------------------------------------------------------------------------------
// websocket_frame_receiver_test
// Self-checking bench for the WebSocket frame receiver. A short table of
// hand-made frames comes first. Random client frames follow under several
// payload limits, at first with random stalls on both channels. The run ends
// with an optional close and one protocol error, after which the block must
// stay silent. Results not set by the table are checked against a byte-level deframer.
//------------------------------------------------------------------------------
`default_nettype none

module websocket_frame_receiver_test;

    import wsfr_pkg::*;

    localparam int unsigned RUN_LIMIT = 2_000_000;

    typedef enum int {
        ENC_LEN7,
        ENC_LEN16,
        ENC_LEN64
    } len_enc_t;

    typedef struct {
        logic [7:0]   rx;
        bit           typed;
        wsfr_result_t want;
    } stim_row_t;

    localparam wsfr_result_t NO_RESULT = '0;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [31:0] cfg_wr_data = 32'd0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte     = 8'd0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [3:0]  opcode;
    logic        frame_end;
    logic        message_end;
    logic [1:0]  error_code;

    int send_idle_pct = 27;
    int recv_idle_pct = 65;
    int mismatch_count = 0;
    int bytes_sent = 0;

    wsfr_result_t predicted_results[$];
    stim_row_t    opening_rows[$];

    // Deframer state tracked alongside the block.
    phase_t      trk_phase;
    logic [3:0]  trk_count;
    logic        trk_fin;
    logic [3:0]  trk_op;
    logic        trk_frag;
    logic [63:0] trk_len;
    logic [31:0] trk_left;
    logic [31:0] trk_key;
    logic [1:0]  trk_midx;
    logic        trk_closed;
    logic        trk_dead;
    logic [31:0] trk_limit;

    websocket_frame_receiver DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .data        (data),
        .opcode      (opcode),
        .frame_end   (frame_end),
        .message_end (message_end),
        .error_code  (error_code)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic wsfr_result_t make_result(kind_t k, logic [7:0] d, logic [3:0] op,
                                                 logic fe, logic me, err_t e);
        wsfr_result_t r;
        r.kind        = k;
        r.data        = d;
        r.opcode      = op;
        r.frame_end   = fe;
        r.message_end = me;
        r.error_code  = e;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
    endtask

    task automatic close_out_frame();
        if (trk_fin)
        begin
            trk_frag = 1'b0;
            if (trk_op == OPC_CLOSE)
                trk_closed = 1'b1;
        end
        else
        begin
            trk_frag = 1'b1;
        end
        trk_phase = PH_HDR0;
        trk_count = 4'd0;
        trk_midx  = 2'd0;
    endtask

    // Advances the tracked deframer by one received byte.
    task automatic deframe_byte(input logic [7:0] b, output bit made, output wsfr_result_t res);
        err_t       fault;
        logic [7:0] key_byte;
        logic       last;
        made  = 1'b0;
        res   = NO_RESULT;
        fault = ERR_NONE;
        if (!trk_dead)
        begin
            case (trk_phase)
                PH_HDR0:
                begin
                    trk_fin = b[7];
                    if (!trk_frag)
                        trk_op = b[3:0];
                    trk_count = ((b & RSV_BITS) != 8'd0) ? 4'd1 : 4'd0;
                    trk_phase = PH_HDR1;
                end
                PH_HDR1:
                begin
                    if (trk_count != 4'd0)
                        fault = ERR_RSV;
                    else if (!b[7])
                        fault = ERR_MASK;
                    else
                    begin
                        trk_len = 64'd0;
                        if (b[6:0] == LEN_EXT16)
                        begin
                            trk_count = HCNT_EXT16;
                            trk_phase = PH_EXT;
                        end
                        else if (b[6:0] == LEN_EXT64)
                        begin
                            trk_count = HCNT_EXT64;
                            trk_phase = PH_EXT;
                        end
                        else if ({57'd0, b[6:0]} > {32'd0, trk_limit})
                            fault = ERR_SIZE;
                        else
                        begin
                            trk_left  = {25'd0, b[6:0]};
                            trk_count = HCNT_MASK;
                            trk_phase = PH_MASK;
                        end
                    end
                end
                PH_EXT:
                begin
                    trk_len   = {trk_len[55:0], b};
                    trk_count = trk_count - 4'd1;
                    if (trk_count == 4'd0)
                    begin
                        if (trk_len > {32'd0, trk_limit})
                            fault = ERR_SIZE;
                        else
                        begin
                            trk_left  = trk_len[31:0];
                            trk_count = HCNT_MASK;
                            trk_phase = PH_MASK;
                        end
                    end
                end
                PH_MASK:
                begin
                    trk_key   = {trk_key[23:0], b};
                    trk_count = trk_count - 4'd1;
                    if (trk_count == 4'd0)
                    begin
                        trk_midx = 2'd0;
                        if (trk_left == 32'd0)
                        begin
                            if (!trk_closed)
                            begin
                                made = 1'b1;
                                res  = make_result(KIND_EMPTY, 8'd0, trk_op, 1'b1, trk_fin,
                                                   ERR_NONE);
                            end
                            close_out_frame();
                        end
                        else
                            trk_phase = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    key_byte = trk_key[8 * (3 - int'(trk_midx)) +: 8];
                    trk_midx = trk_midx + 2'd1;
                    trk_left = trk_left - 32'd1;
                    last     = (trk_left == 32'd0);
                    if (!trk_closed)
                    begin
                        made = 1'b1;
                        res  = make_result(KIND_DATA, b ^ key_byte, trk_op, last,
                                           last & trk_fin, ERR_NONE);
                    end
                    if (last)
                        close_out_frame();
                end
                default:
                    trk_phase = PH_HDR0;
            endcase
            if (fault != ERR_NONE)
            begin
                trk_dead = 1'b1;
                made     = 1'b1;
                res      = make_result(KIND_ERROR, 8'd0, 4'd0, 1'b0, 1'b0, fault);
            end
        end
    endtask

    // One transfer on the input channel; valid stays high into the next byte
    // unless the sender decides to idle first.
    task automatic send_byte(input logic [7:0] b, input bit typed, input wsfr_result_t want);
        bit           made;
        wsfr_result_t res;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        deframe_byte(b, made, res);
        if (typed)
            predicted_results.push_back(want);
        else if (made)
            predicted_results.push_back(res);
    endtask

    task automatic send_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                              input logic masked, input len_enc_t enc, input logic [63:0] len,
                              input int body);
        logic [6:0] len7;
        int         ext_bytes;
        case (enc)
            ENC_LEN16:
            begin
                len7      = LEN_EXT16;
                ext_bytes = 2;
            end
            ENC_LEN64:
            begin
                len7      = LEN_EXT64;
                ext_bytes = 8;
            end
            default:
            begin
                len7      = len[6:0];
                ext_bytes = 0;
            end
        endcase
        send_byte({fin, rsv, op}, 1'b0, NO_RESULT);
        send_byte({masked, len7}, 1'b0, NO_RESULT);
        for (int i = ext_bytes - 1; i >= 0; i--)
            send_byte(len[8 * i +: 8], 1'b0, NO_RESULT);
        repeat (4) send_byte(8'($urandom), 1'b0, NO_RESULT);
        repeat (body) send_byte(8'($urandom), 1'b0, NO_RESULT);
    endtask

    // A well-formed masked frame whose length fits the given limit.
    task automatic random_frame(input logic [31:0] lim);
        logic [63:0] len;
        logic [3:0]  op;
        logic        fin;
        len_enc_t    enc;
        int          r;
        r = $urandom_range(0, 99);
        if (r < 10 && lim <= 400)
            len = {32'd0, lim};
        else if (r < 55)
            len = $urandom_range(0, (lim < 12) ? lim : 12);
        else if (r < 80)
            len = $urandom_range(0, (lim < 125) ? lim : 125);
        else
            len = $urandom_range(0, (lim < 400) ? lim : 400);
        r = $urandom_range(0, 99);
        if (len > 125)
            enc = (r < 50) ? ENC_LEN16 : ENC_LEN64;
        else
            enc = (r < 70) ? ENC_LEN7 : (r < 85) ? ENC_LEN16 : ENC_LEN64;
        fin = ($urandom_range(0, 99) < 70);
        // A close opcode may only show up where it is ignored, inside a fragment.
        if (trk_frag)
            op = 4'($urandom);
        else if ($urandom_range(0, 1) == 1)
            op = 4'($urandom_range(1, 2));
        else
        begin
            do
                op = 4'($urandom);
            while (op == OPC_CLOSE);
        end
        send_frame(fin, 3'd0, op, 1'b1, enc, len, int'(len));
    endtask

    task automatic random_stream(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            random_frame(trk_limit);
    endtask

    task automatic write_limit(input logic [31:0] value);
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        trk_limit = value;
    endtask

    task automatic add_row(input logic [7:0] rx, input bit typed, input wsfr_result_t want);
        stim_row_t row;
        row.rx    = rx;
        row.typed = typed;
        row.want  = want;
        opening_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin : check_results
        wsfr_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (predicted_results.size() == 0)
                report_mismatch("result transfer with nothing expected");
            else
            begin
                want = predicted_results.pop_front();
                check_field("kind", {6'd0, kind}, {6'd0, want.kind});
                check_field("data", data, want.data);
                check_field("opcode", {4'd0, opcode}, {4'd0, want.opcode});
                check_field("frame_end", {7'd0, frame_end}, {7'd0, want.frame_end});
                check_field("message_end", {7'd0, message_end}, {7'd0, want.message_end});
                check_field("error_code", {6'd0, error_code}, {6'd0, want.error_code});
            end
        end
    end

    initial
    begin : stimulus
        err_t        fault;
        logic [63:0] len;
        int          pick;
        trk_phase  = PH_HDR0;
        trk_count  = 4'd0;
        trk_fin    = 1'b0;
        trk_op     = 4'd0;
        trk_frag   = 1'b0;
        trk_len    = 64'd0;
        trk_left   = 32'd0;
        trk_key    = 32'd0;
        trk_midx   = 2'd0;
        trk_closed = 1'b0;
        trk_dead   = 1'b0;
        trk_limit  = MAX_PAYLOAD_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty text frame with FIN: a single marker right after the mask key.
        add_row(8'h81, 1'b0, NO_RESULT);
        add_row(8'h80, 1'b0, NO_RESULT);
        add_row(8'h12, 1'b0, NO_RESULT);
        add_row(8'h34, 1'b0, NO_RESULT);
        add_row(8'h56, 1'b0, NO_RESULT);
        add_row(8'h78, 1'b1, make_result(KIND_EMPTY, 8'h00, 4'h1, 1'b1, 1'b1, ERR_NONE));
        // First fragment of a binary message, two bytes under key FF 00 AA 55.
        add_row(8'h02, 1'b0, NO_RESULT);
        add_row(8'h82, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'hAA, 1'b0, NO_RESULT);
        add_row(8'h55, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b1, make_result(KIND_DATA, 8'hFF, 4'h2, 1'b0, 1'b0, ERR_NONE));
        add_row(8'hFF, 1'b1, make_result(KIND_DATA, 8'hFF, 4'h2, 1'b1, 1'b0, ERR_NONE));
        // Final fragment carrying a ping opcode and a 16-bit length of one; the
        // message keeps its binary opcode.
        add_row(8'h89, 1'b0, NO_RESULT);
        add_row(8'hFE, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h01, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'h00, 1'b0, NO_RESULT);
        add_row(8'hFF, 1'b1, make_result(KIND_DATA, 8'hFF, 4'h2, 1'b1, 1'b1, ERR_NONE));

        foreach (opening_rows[i])
            send_byte(opening_rows[i].rx, opening_rows[i].typed, opening_rows[i].want);

        random_stream(400);

        write_limit(32'hFFFF_FFFF);
        send_idle_pct = 65;
        recv_idle_pct = 27;
        send_frame(1'b1, 3'd0, 4'h2, 1'b1, ENC_LEN16, 64'd0, 0);
        random_stream(400);

        write_limit(32'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_stream(100);

        write_limit(32'($urandom_range(1, 200)));
        random_stream(400);

        // Closing sequence: optionally close the stream, then one protocol error.
        if ($urandom_range(0, 1) == 1)
        begin
            if (trk_frag)
                send_frame(1'b1, 3'd0, 4'h0, 1'b1, ENC_LEN7, 64'd2, 2);
            if ($urandom_range(0, 1) == 1)
            begin
                send_frame(1'b0, 3'd0, OPC_CLOSE, 1'b1, ENC_LEN7, 64'd2, 2);
                send_frame(1'b1, 3'd0, 4'h0, 1'b1, ENC_LEN7, 64'd0, 0);
            end
            else
                send_frame(1'b1, 3'd0, OPC_CLOSE, 1'b1, ENC_LEN7, 64'd2, 2);
            // Payload and empty-frame output must now be suppressed.
            repeat (3) random_frame(trk_limit);
        end

        fault = err_t'($urandom_range(1, 3));
        case (fault)
            ERR_RSV:
                send_frame(1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom), 1'($urandom),
                           ENC_LEN7, 64'($urandom_range(0, 127)), 4);
            ERR_MASK:
                send_frame(1'($urandom), 3'd0, 4'($urandom), 1'b0, ENC_LEN7,
                           64'($urandom_range(0, 127)), 4);
            default:
            begin
                pick = $urandom_range(0, 2);
                if (pick == 0 && trk_limit < 125)
                    send_frame(1'b1, 3'd0, 4'h2, 1'b1, ENC_LEN7,
                               64'($urandom_range(trk_limit + 1, 125)), 4);
                else if (pick == 1 && trk_limit < 32768)
                    // A 16-bit length with its top bit set is a large unsigned count.
                    send_frame(1'b1, 3'd0, 4'h2, 1'b1, ENC_LEN16,
                               64'd32768 + 64'($urandom_range(0, 255)), 4);
                else
                begin
                    len = ($urandom_range(0, 1) == 1) ? {32'd0, trk_limit} + 64'd1
                                                      : {$urandom, $urandom};
                    if (len <= {32'd0, trk_limit})
                        len = {32'd0, trk_limit} + 64'd1;
                    send_frame(1'b1, 3'd0, 4'h2, 1'b1, ENC_LEN64, len, 4);
                end
            end
        endcase
        // The block is dead now; these bytes must be swallowed silently.
        repeat (20) send_byte(8'($urandom), 1'b0, NO_RESULT);

        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/wsfr_pkg.sv
rtl/core/wsfr_parse.sv
rtl/core/wsfr_obuf.sv
rtl/core/websocket_frame_receiver.sv
rtl/core/wsfr_check.sv
bench/websocket_frame_receiver_test.sv
